// ----- hdl/tfp_pkg.sv -----
// tfp_pkg: shared types, register indexes and helpers for the texel filter,
// premultiply and pack block. No dependencies.

package tfp_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_RED   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_GREEN = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_BLUE  = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_ALPHA = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_COLOR = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LIMIT = 8'd7;

    // colour modes
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_GREY   = 2'd1;
    localparam logic [1:0] MODE_FILTER = 2'd2;

    // output formats
    localparam logic [1:0] FMT_RGBA8888 = 2'd0;
    localparam logic [1:0] FMT_RGB565   = 2'd1;
    localparam logic [1:0] FMT_RGBA5551 = 2'd2;
    localparam logic [1:0] FMT_RGBA4444 = 2'd3;

    // luma weights
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd151;
    localparam logic [7:0] LUMA_B = 8'd28;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_HALF   = 8'd128;

    localparam logic [15:0] UNITY_Q88 = 16'd256;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  fmt;
        logic        premul;
        logic [8:0]  thresh;
        logic [15:0] gain_red;
        logic [15:0] gain_green;
        logic [15:0] gain_blue;
        logic [15:0] gain_alpha;
        logic [15:0] brightness;
        logic [7:0]  clip_red;
        logic [7:0]  clip_green;
        logic [7:0]  clip_blue;
        logic [17:0] clip_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // floor(x / 255), exact for any x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [7:0] sat8_24(input logic [23:0] x);
        return (|x[23:8]) ? 8'hFF : x[7:0];
    endfunction

endpackage

// ----- hdl/tfp_cfg.sv -----
// tfp_cfg: configuration register file for the texel block.
// Depends on tfp_pkg.

module tfp_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tfp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tfp_pkg::cfg_t                   cfg
);
    import tfp_pkg::*;

    logic [13:0] control_reg;
    logic [15:0] gain_red_reg;
    logic [15:0] gain_green_reg;
    logic [15:0] gain_blue_reg;
    logic [15:0] gain_alpha_reg;
    logic [15:0] brightness_reg;
    logic [23:0] clip_color_reg;
    logic [17:0] clip_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg    <= '0;
            gain_red_reg   <= UNITY_Q88;
            gain_green_reg <= UNITY_Q88;
            gain_blue_reg  <= UNITY_Q88;
            gain_alpha_reg <= UNITY_Q88;
            brightness_reg <= UNITY_Q88;
            clip_color_reg <= '0;
            clip_limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CONTROL:    control_reg    <= cfg_data[13:0];
                REG_GAIN_RED:   gain_red_reg   <= cfg_data[15:0];
                REG_GAIN_GREEN: gain_green_reg <= cfg_data[15:0];
                REG_GAIN_BLUE:  gain_blue_reg  <= cfg_data[15:0];
                REG_GAIN_ALPHA: gain_alpha_reg <= cfg_data[15:0];
                REG_BRIGHTNESS: brightness_reg <= cfg_data[15:0];
                REG_CLIP_COLOR: clip_color_reg <= cfg_data[23:0];
                REG_CLIP_LIMIT: clip_limit_reg <= cfg_data[17:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg.mode       = control_reg[1:0];
        cfg.fmt        = control_reg[3:2];
        cfg.premul     = control_reg[4];
        cfg.thresh     = control_reg[13:5];
        cfg.gain_red   = gain_red_reg;
        cfg.gain_green = gain_green_reg;
        cfg.gain_blue  = gain_blue_reg;
        cfg.gain_alpha = gain_alpha_reg;
        cfg.brightness = brightness_reg;
        cfg.clip_red   = clip_color_reg[7:0];
        cfg.clip_green = clip_color_reg[15:8];
        cfg.clip_blue  = clip_color_reg[23:16];
        cfg.clip_limit = clip_limit_reg;
    end

endmodule

// ----- hdl/tfp_color.sv -----
// tfp_color: two pipeline stages applying pass, grey or filter mode.
// Depends on tfp_pkg.

module tfp_color (
    input  logic          clk,
    input  logic          rst_n,
    input  tfp_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  tfp_pkg::pix_t in_pix,
    output logic          out_valid,
    input  logic          out_ready,
    output tfp_pkg::pix_t out_pix
);
    import tfp_pkg::*;

    logic        v1_reg;
    logic        v2_reg;
    logic        en1;
    logic        en2;
    pix_t        pix1_reg;
    logic [23:0] pr_reg;
    logic [23:0] pg_reg;
    logic [23:0] pb_reg;
    logic [23:0] pa_reg;
    logic [15:0] luma_reg;
    pix_t        pix2_next;
    pix_t        pix2_reg;
    logic [39:0] fr;
    logic [39:0] fg;
    logic [39:0] fb;
    logic [39:0] fa;
    logic [31:0] grey_full;
    logic [7:0]  grey;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    // stage one: channel times gain, weighted luma
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            pix1_reg <= in_pix;
            pr_reg   <= 24'(in_pix.red)   * 24'(cfg.gain_red);
            pg_reg   <= 24'(in_pix.green) * 24'(cfg.gain_green);
            pb_reg   <= 24'(in_pix.blue)  * 24'(cfg.gain_blue);
            pa_reg   <= 24'(in_pix.alpha) * 24'(cfg.gain_alpha);
            luma_reg <= 16'(16'(LUMA_R) * 16'(in_pix.red)
                          + 16'(LUMA_G) * 16'(in_pix.green)
                          + 16'(LUMA_B) * 16'(in_pix.blue));
        end
    end

    // stage two: times brightness, saturate, select mode
    always_comb
    begin
        fr        = 40'(pr_reg) * 40'(cfg.brightness);
        fg        = 40'(pg_reg) * 40'(cfg.brightness);
        fb        = 40'(pb_reg) * 40'(cfg.brightness);
        fa        = 40'(pa_reg) * 40'(cfg.brightness);
        grey_full = 32'(luma_reg) * 32'(cfg.brightness);
        grey      = (|grey_full[31:24]) ? 8'hFF : grey_full[23:16];
        case (cfg.mode)
            MODE_GREY:
            begin
                pix2_next.red   = grey;
                pix2_next.green = grey;
                pix2_next.blue  = grey;
                pix2_next.alpha = pix1_reg.alpha;
            end
            MODE_FILTER:
            begin
                pix2_next.red   = sat8_24(fr[39:16]);
                pix2_next.green = sat8_24(fg[39:16]);
                pix2_next.blue  = sat8_24(fb[39:16]);
                pix2_next.alpha = sat8_24(fa[39:16]);
            end
            default:
                pix2_next = pix1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
            pix2_reg <= pix2_next;
    end

    assign out_valid = v2_reg;
    assign out_pix   = pix2_reg;

endmodule

// ----- hdl/tfp_premul.sv -----
// tfp_premul: alpha clip test, premultiply and format packing in two stages,
// the second being the output register. Depends on tfp_pkg.

module tfp_premul (
    input  logic          clk,
    input  logic          rst_n,
    input  tfp_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  tfp_pkg::pix_t in_pix,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   out_word,
    output logic          out_clipped
);
    import tfp_pkg::*;

    logic        v3_reg;
    logic        vo_reg;
    logic        en3;
    logic        eno;
    pix_t        pix3_reg;
    logic [17:0] len_reg;
    logic [15:0] ra_reg;
    logic [15:0] ga_reg;
    logic [15:0] ba_reg;
    logic [17:0] len_next;
    logic [17:0] clen;
    logic [17:0] diff;
    logic        do_premul;
    logic        clip;
    pix_t        res;
    logic [31:0] word_next;
    logic [31:0] word_reg;
    logic        clipped_reg;

    assign eno      = !vo_reg || out_ready;
    assign en3      = !v3_reg || eno;
    assign in_ready = en3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en3)
                v3_reg <= in_valid;
            if (eno)
                vo_reg <= v3_reg;
        end
    end

    // stage three: squared length and colour times alpha
    assign len_next = 18'(16'(in_pix.red) * 16'(in_pix.red))
                    + 18'(16'(in_pix.green) * 16'(in_pix.green))
                    + 18'(16'(in_pix.blue) * 16'(in_pix.blue));

    always_ff @(posedge clk)
    begin
        if (en3 && in_valid)
        begin
            pix3_reg <= in_pix;
            len_reg  <= len_next;
            ra_reg   <= 16'(in_pix.red)   * 16'(in_pix.alpha);
            ga_reg   <= 16'(in_pix.green) * 16'(in_pix.alpha);
            ba_reg   <= 16'(in_pix.blue)  * 16'(in_pix.alpha);
        end
    end

    // stage four: clip decision, divide by 255, pack
    always_comb
    begin
        clen = 18'(16'(cfg.clip_red) * 16'(cfg.clip_red))
             + 18'(16'(cfg.clip_green) * 16'(cfg.clip_green))
             + 18'(16'(cfg.clip_blue) * 16'(cfg.clip_blue));
        diff      = (len_reg >= clen) ? (len_reg - clen) : (clen - len_reg);
        do_premul = cfg.premul && (pix3_reg.alpha != ALPHA_OPAQUE);
        clip      = do_premul && ({1'b0, pix3_reg.alpha} < cfg.thresh)
                    && (diff <= cfg.clip_limit);
        if (clip)
            res = '0;
        else if (do_premul)
        begin
            res.red   = div255(ra_reg);
            res.green = div255(ga_reg);
            res.blue  = div255(ba_reg);
            res.alpha = pix3_reg.alpha;
        end
        else
            res = pix3_reg;

        case (cfg.fmt)
            FMT_RGBA8888:
                word_next = {res.alpha, res.blue, res.green, res.red};
            FMT_RGB565:
                word_next = {16'd0, res.red[7:3], res.green[7:2], res.blue[7:3]};
            FMT_RGBA5551:
                word_next = {16'd0, res.red[7:3], res.green[7:3], res.blue[7:3],
                             (res.alpha > ALPHA_HALF)};
            default:
                word_next = {16'd0, res.red[7:4], res.green[7:4], res.blue[7:4],
                             res.alpha[7:4]};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (eno && v3_reg)
        begin
            word_reg    <= word_next;
            clipped_reg <= clip;
        end
    end

    assign out_valid   = vo_reg;
    assign out_word    = word_reg;
    assign out_clipped = clipped_reg;

endmodule

// ----- hdl/texel_filter_premultiply_pack.sv -----
// texel_filter_premultiply_pack: top level of the texel converter.
// Depends on tfp_pkg, tfp_cfg, tfp_color and tfp_premul.
//
// Input stream s_*: one RGBA8888 texel per beat, red in tdata 7:0 up to
// alpha in 31:24. Output stream m_*: the packed texel word in tdata and the
// clip flag in tuser, one beat per input beat, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index 0..7 (control, four
// gains, brightness, clip colour, clip limit) and cfg_data; other indexes
// are ignored. cfg_ready is always high. Write only while the pipe is empty.
// Pipeline: four register stages (gain product, brightness product and mode
// select, squares and alpha products, clip test with divide and pack) lie
// between an accepted input beat and m_tvalid; throughput one texel per
// cycle while the receiver keeps m_tready high.
// Reset clears all stage valid bits and loads the register reset values;
// no clearing pass is needed.
// When the receiver stalls, the output beat holds and bubbles in the pipe
// are still filled; s_tready drops only once every stage is occupied.

module texel_filter_premultiply_pack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // red, green, blue, alpha
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // pixel_word
    output logic                            m_tuser,   // clipped
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tfp_pkg::*;

    cfg_t cfg;
    pix_t in_pix;
    pix_t mid_pix;
    logic mid_valid;
    logic mid_ready;

    assign in_pix = s_tdata;

    tfp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tfp_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (in_pix),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_pix   (mid_pix)
    );

    tfp_premul u_premul (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (mid_valid),
        .in_ready    (mid_ready),
        .in_pix      (mid_pix),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_word    (m_tdata),
        .out_clipped (m_tuser)
    );

endmodule

// ----- hdl/tfp_checker.sv -----
// tfp_checker: port-level assertions for the texel converter, bound to the
// top level. Depends on texel_filter_premultiply_pack.

module tfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // a clipped texel is all zero
    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("clipped texel not zero");

    // empty output stage means the pipe can take a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

    // an accepted beat reaches the output through every stage while the receiver stays ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

    // nothing leaves during reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind texel_filter_premultiply_pack tfp_checker u_tfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/tb_texel_filter_premultiply_pack.sv -----
// tb_texel_filter_premultiply_pack: self-checking testbench for the texel filter,
// premultiply and pack block, with a directed script, random phases and random stalls.
// Depends on tfp_pkg and texel_filter_premultiply_pack.
`timescale 1ns / 100ps

module tb_texel_filter_premultiply_pack;

    import tfp_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASE_COUNT     = 12;
    localparam int TEXELS_PER_PHASE = 112;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [31:0] word;
        logic        clipped;
    } texel_result_t;

    typedef struct {
        logic          is_reg;
        logic [7:0]    index;
        logic [31:0]   value;
        logic          typed;
        texel_result_t known;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    cfg_t          settings;
    texel_result_t pending_texels[$];
    script_row_t   directed_script[$];
    int            fault_count = 0;
    int            idle_cycles = 0;
    int            stall_left = 0;
    logic          calm = 1'b0;

    texel_filter_premultiply_pack uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        if (calm)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] make_control(input logic [1:0] mode, input logic [1:0] fmt,
                                                 input logic premul, input logic [8:0] thresh);
        return {18'd0, thresh, premul, fmt, mode};
    endfunction

    function automatic logic [7:0] clamp_byte(input logic [63:0] v);
        return (v > 64'd255) ? 8'hFF : v[7:0];
    endfunction

    function automatic logic [7:0] gain_scale(input logic [7:0] c, input logic [15:0] gain);
        return clamp_byte((64'(c) * gain * settings.brightness) >> 16);
    endfunction

    function automatic void reset_settings();
        settings = '0;
        settings.gain_red   = UNITY_Q88;
        settings.gain_green = UNITY_Q88;
        settings.gain_blue  = UNITY_Q88;
        settings.gain_alpha = UNITY_Q88;
        settings.brightness = UNITY_Q88;
    endfunction

    function automatic void apply_reg(input logic [7:0] index, input logic [31:0] value);
        case (index)
            REG_CONTROL:
            begin
                settings.mode   = value[1:0];
                settings.fmt    = value[3:2];
                settings.premul = value[4];
                settings.thresh = value[13:5];
            end
            REG_GAIN_RED:   settings.gain_red   = value[15:0];
            REG_GAIN_GREEN: settings.gain_green = value[15:0];
            REG_GAIN_BLUE:  settings.gain_blue  = value[15:0];
            REG_GAIN_ALPHA: settings.gain_alpha = value[15:0];
            REG_BRIGHTNESS: settings.brightness = value[15:0];
            REG_CLIP_COLOR:
            begin
                settings.clip_red   = value[7:0];
                settings.clip_green = value[15:8];
                settings.clip_blue  = value[23:16];
            end
            REG_CLIP_LIMIT: settings.clip_limit = value[17:0];
            default: ;
        endcase
    endfunction

    function automatic texel_result_t convert_texel(input pix_t px);
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
        logic [7:0]    a;
        logic [63:0]   luma;
        logic [31:0]   len;
        logic [31:0]   clen;
        logic [31:0]   diff;
        texel_result_t res;
        r = px.red;
        g = px.green;
        b = px.blue;
        a = px.alpha;
        res.clipped = 1'b0;
        case (settings.mode)
            MODE_GREY:
            begin
                luma = 64'(LUMA_R) * r + 64'(LUMA_G) * g + 64'(LUMA_B) * b;
                r = clamp_byte((luma * settings.brightness) >> 16);
                g = r;
                b = r;
            end
            MODE_FILTER:
            begin
                r = gain_scale(r, settings.gain_red);
                g = gain_scale(g, settings.gain_green);
                b = gain_scale(b, settings.gain_blue);
                a = gain_scale(a, settings.gain_alpha);
            end
            default: ;
        endcase
        if (settings.premul && a != ALPHA_OPAQUE)
        begin
            len  = 32'(r) * r + 32'(g) * g + 32'(b) * b;
            clen = 32'(settings.clip_red) * settings.clip_red
                 + 32'(settings.clip_green) * settings.clip_green
                 + 32'(settings.clip_blue) * settings.clip_blue;
            diff = (len >= clen) ? len - clen : clen - len;
            if (9'(a) < settings.thresh && diff <= 32'(settings.clip_limit))
            begin
                r = 8'd0;
                g = 8'd0;
                b = 8'd0;
                a = 8'd0;
                res.clipped = 1'b1;
            end
            else
            begin
                r = 8'((32'(r) * a) / 255);
                g = 8'((32'(g) * a) / 255);
                b = 8'((32'(b) * a) / 255);
            end
        end
        case (settings.fmt)
            FMT_RGBA8888: res.word = {a, b, g, r};
            FMT_RGB565:   res.word = {16'd0, r[7:3], g[7:2], b[7:3]};
            FMT_RGBA5551: res.word = {16'd0, r[7:3], g[7:3], b[7:3], a > ALPHA_HALF};
            default:      res.word = {16'd0, r[7:4], g[7:4], b[7:4], a[7:4]};
        endcase
        return res;
    endfunction

    function automatic script_row_t reg_row(input logic [7:0] index, input logic [31:0] value);
        script_row_t row;
        row = '{1'b1, index, value, 1'b0, '0};
        return row;
    endfunction

    function automatic script_row_t texel_row(input logic [31:0] px);
        script_row_t row;
        row = '{1'b0, 8'd0, px, 1'b0, '0};
        return row;
    endfunction

    function automatic script_row_t known_row(input logic [31:0] px, input logic [31:0] word,
                                              input logic clipped);
        script_row_t row;
        row = '{1'b0, 8'd0, px, 1'b1, '{word, clipped}};
        return row;
    endfunction

    function automatic logic [7:0] near_byte(input logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 255)
        begin
            v = 255;
        end
        return 8'(v);
    endfunction

    function automatic logic [7:0] edge_byte();
        case ($urandom_range(0, 2))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pix_t draw_texel();
        int   kind;
        pix_t px;
        kind = $urandom_range(0, 9);
        px = $urandom();
        if (kind < 4)
        begin
            px.red   = near_byte(settings.clip_red);
            px.green = near_byte(settings.clip_green);
            px.blue  = near_byte(settings.clip_blue);
            px.alpha = 8'($urandom_range(0, 254));
        end
        else if (kind < 6)
        begin
            px.red   = edge_byte();
            px.green = edge_byte();
            px.blue  = edge_byte();
            px.alpha = edge_byte();
        end
        return px;
    endfunction

    function automatic logic [15:0] draw_q88();
        case ($urandom_range(0, 3))
            0: return UNITY_Q88;
            1: return 16'($urandom_range(0, 512));
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(200, 300));
        endcase
    endfunction

    task automatic write_reg(input logic [7:0] index, input logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_texels.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        apply_reg(index, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_texel(input pix_t px, input logic typed, input texel_result_t known);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_texels.push_back(typed ? known : convert_texel(px));
    endtask

    task automatic load_settings(input logic [31:0] control, input logic [15:0] gr,
                                 input logic [15:0] gg, input logic [15:0] gb,
                                 input logic [15:0] ga, input logic [15:0] br,
                                 input logic [23:0] color, input logic [17:0] limit);
        write_reg(REG_CONTROL, control);
        write_reg(REG_GAIN_RED, 32'(gr));
        write_reg(REG_GAIN_GREEN, 32'(gg));
        write_reg(REG_GAIN_BLUE, 32'(gb));
        write_reg(REG_GAIN_ALPHA, 32'(ga));
        write_reg(REG_BRIGHTNESS, 32'(br));
        write_reg(REG_CLIP_COLOR, 32'(color));
        write_reg(REG_CLIP_LIMIT, 32'(limit));
    endtask

    task automatic report_fault(input string what);
        if (fault_count < REPORT_LIMIT)
        begin
            $display("mismatch: %s", what);
        end
        fault_count++;
    endtask

    // output side: random stalls and scoreboard
    always @(posedge clk or negedge rst_n)
    begin
        texel_result_t want;
        int            gap;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_texels.size() == 0)
                begin
                    report_fault($sformatf("unexpected beat word=%h clipped=%b",
                                           m_tdata, m_tuser));
                end
                else
                begin
                    want = pending_texels.pop_front();
                    if (m_tdata !== want.word)
                    begin
                        report_fault($sformatf("pixel_word expected %h actual %h",
                                               want.word, m_tdata));
                    end
                    if (m_tuser !== want.clipped)
                    begin
                        report_fault($sformatf("clipped expected %b actual %b",
                                               want.clipped, m_tuser));
                    end
                end
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    stall_left = gap - 1;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("texel_filter_premultiply_pack test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        script_row_t   row;
        texel_result_t none;
        logic [31:0]   control;
        none = '0;
        reset_settings();

        // reset values: pass, RGBA8888, then pass through each other format
        directed_script.push_back(known_row(32'h00000000, 32'h00000000, 1'b0));
        directed_script.push_back(known_row(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0));
        directed_script.push_back(known_row(32'h80FF0001, 32'h80FF0001, 1'b0));
        directed_script.push_back(reg_row(REG_CONTROL, make_control(MODE_PASS, FMT_RGB565, 1'b0, 9'd0)));
        directed_script.push_back(known_row(32'hFFFFFFFF, 32'h0000FFFF, 1'b0));
        directed_script.push_back(known_row(32'h00000000, 32'h00000000, 1'b0));
        directed_script.push_back(reg_row(REG_CONTROL, make_control(MODE_PASS, FMT_RGBA5551, 1'b0, 9'd0)));
        directed_script.push_back(known_row(32'hFFFFFFFF, 32'h0000FFFF, 1'b0));
        directed_script.push_back(known_row(32'h80FFFFFF, 32'h0000FFFE, 1'b0));
        directed_script.push_back(known_row(32'h81000000, 32'h00000001, 1'b0));
        directed_script.push_back(reg_row(REG_CONTROL, make_control(MODE_PASS, FMT_RGBA4444, 1'b0, 9'd0)));
        directed_script.push_back(known_row(32'hFFFFFFFF, 32'h0000FFFF, 1'b0));
        directed_script.push_back(known_row(32'h12345678, 32'h00007531, 1'b0));
        // grey with brightness extremes
        directed_script.push_back(reg_row(REG_CONTROL, make_control(MODE_GREY, FMT_RGBA8888, 1'b0, 9'd0)));
        directed_script.push_back(known_row(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0));
        directed_script.push_back(texel_row(32'h00123456));
        directed_script.push_back(reg_row(REG_BRIGHTNESS, 32'h0000FFFF));
        directed_script.push_back(known_row(32'h00010101, 32'h00FFFFFF, 1'b0));
        // filter saturation and zero brightness
        directed_script.push_back(reg_row(REG_CONTROL, make_control(MODE_FILTER, FMT_RGBA8888, 1'b0, 9'd0)));
        directed_script.push_back(known_row(32'h01010101, 32'hFFFFFFFF, 1'b0));
        directed_script.push_back(reg_row(REG_BRIGHTNESS, 32'h00000000));
        directed_script.push_back(known_row(32'hFFFFFFFF, 32'h00000000, 1'b0));
        directed_script.push_back(reg_row(REG_BRIGHTNESS, 32'(UNITY_Q88)));
        directed_script.push_back(reg_row(REG_GAIN_RED, 32'd512));
        directed_script.push_back(reg_row(REG_GAIN_GREEN, 32'd128));
        directed_script.push_back(reg_row(REG_GAIN_BLUE, 32'd0));
        directed_script.push_back(reg_row(REG_GAIN_ALPHA, 32'h0000FFFF));
        directed_script.push_back(texel_row(32'h40808080));
        // mode three acts as pass
        directed_script.push_back(reg_row(REG_CONTROL, 32'd3));
        directed_script.push_back(known_row(32'h12345678, 32'h12345678, 1'b0));
        // premultiply, zero threshold
        directed_script.push_back(reg_row(REG_CONTROL, make_control(MODE_PASS, FMT_RGBA8888, 1'b1, 9'd0)));
        directed_script.push_back(known_row(32'h80FFFFFF, 32'h80808080, 1'b0));
        directed_script.push_back(known_row(32'h00FFFFFF, 32'h00000000, 1'b0));
        directed_script.push_back(known_row(32'hFF123456, 32'hFF123456, 1'b0));
        // alpha clip
        directed_script.push_back(reg_row(REG_CONTROL, make_control(MODE_PASS, FMT_RGBA8888, 1'b1, 9'd511)));
        directed_script.push_back(known_row(32'h00000000, 32'h00000000, 1'b1));
        directed_script.push_back(known_row(32'h10000001, 32'h10000000, 1'b0));
        directed_script.push_back(reg_row(REG_CLIP_COLOR, 32'h00030201));
        directed_script.push_back(reg_row(REG_CLIP_LIMIT, 32'd195075));
        directed_script.push_back(known_row(32'hFEFFFFFF, 32'h00000000, 1'b1));
        directed_script.push_back(known_row(32'hFF000000, 32'hFF000000, 1'b0));
        // masked value bits, ignored indexes
        directed_script.push_back(reg_row(REG_CONTROL, 32'hFFFFFFFF));
        directed_script.push_back(reg_row(8'd8, 32'h00000000));
        directed_script.push_back(reg_row(8'd255, 32'h00012345));
        directed_script.push_back(texel_row(32'h7F806040));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_script[i])
        begin
            row = directed_script[i];
            if (row.is_reg)
            begin
                write_reg(row.index, row.value);
            end
            else
            begin
                send_texel(pix_t'(row.value), row.typed, row.known);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            calm = (p % 4 == 3);
            if (p == 0)
            begin
                load_settings(32'h00003FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              24'hFFFFFF, 18'd195075);
            end
            else if (p == 1)
            begin
                load_settings(32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 18'd0);
            end
            else
            begin
                control = make_control(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                       $urandom_range(0, 3) != 0, 9'($urandom_range(0, 511)));
                load_settings(control, draw_q88(), draw_q88(), draw_q88(), draw_q88(),
                              draw_q88(), 24'($urandom_range(0, 24'hFFFFFF)),
                              ($urandom_range(0, 1) != 0) ? 18'($urandom_range(0, 3000))
                                                          : 18'($urandom_range(0, 195075)));
            end
            repeat (TEXELS_PER_PHASE) send_texel(draw_texel(), 1'b0, none);
        end

        s_tvalid <= 1'b0;
        while (pending_texels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending_texels.size() == 0)
        begin
            $display("texel_filter_premultiply_pack test passed");
        end
        else
        begin
            $display("texel_filter_premultiply_pack test failed");
        end
        $finish;
    end

endmodule
